[design/bcr_pkg.sv]
package bcr_pkg;

  // Opcode carried in the input tuser bit.
  localparam logic FUNC_START   = 1'b0;
  localparam logic FUNC_ADVANCE = 1'b1;

  // Each step emits eight mirrored pixels.
  localparam int PHASE_W = 3;
  localparam logic [PHASE_W-1:0] PHASE_FIRST = 3'd0;
  localparam logic [PHASE_W-1:0] PHASE_LAST  = 3'd7;

  // Decision variable constants of the circle recurrence.
  localparam int DEC_INIT     = 3;
  localparam int DEC_STEP_NEG = 6;
  localparam int DEC_STEP_POS = 10;

endpackage

[design/bcr_front.sv]
module bcr_front #(
  parameter int COORD_BITS = 10
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      in_func,
  input  logic [COORD_BITS-1:0]     in_cx,
  input  logic [COORD_BITS-1:0]     in_cy,
  input  logic [COORD_BITS-1:0]     in_radius,
  input  logic                      q_full,
  output logic                      push,
  output logic [4*COORD_BITS:0]     push_data
);

  localparam int DW = COORD_BITS + 4;

  logic [COORD_BITS-1:0] offset_a, offset_b, centre_x_reg, centre_y_reg;
  logic [DW-1:0]         decision;
  logic                  active;

  logic [COORD_BITS-1:0] offset_a_next, offset_b_next, centre_x_next, centre_y_next;
  logic [DW-1:0]         decision_next;
  logic [DW-1:0]         four_x, four_y;
  logic                  done_next;
  logic                  is_start;
  logic                  accept;

  assign four_x   = DW'({offset_a, 2'b00});
  assign four_y   = DW'({offset_b, 2'b00});
  assign is_start = (in_func == bcr_pkg::FUNC_START);

  always_comb begin
    centre_x_next = centre_x_reg;
    centre_y_next = centre_y_reg;
    offset_a_next = offset_a;
    offset_b_next = offset_b;
    decision_next = decision;
    if (is_start) begin
      centre_x_next = in_cx;
      centre_y_next = in_cy;
      offset_a_next = '0;
      offset_b_next = in_radius;
      decision_next = DW'(bcr_pkg::DEC_INIT) - DW'({in_radius, 1'b0});
    end else begin
      // The decision update uses the offsets from before this step.
      if (decision[DW-1]) begin
        decision_next = decision + four_x + DW'(bcr_pkg::DEC_STEP_NEG);
      end else begin
        decision_next = decision + four_x - four_y + DW'(bcr_pkg::DEC_STEP_POS);
        offset_b_next = offset_b - COORD_BITS'(1);
      end
      offset_a_next = offset_a + COORD_BITS'(1);
    end
    done_next = (offset_a_next >= offset_b_next);
  end

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  // An advance while idle is consumed and produces nothing.
  assign push      = accept && (is_start || active);
  assign push_data = {done_next, offset_b_next, offset_a_next, centre_y_next, centre_x_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_a     <= '0;
      offset_b     <= '0;
      decision     <= '0;
      centre_x_reg <= '0;
      centre_y_reg <= '0;
      active       <= 1'b0;
    end else if (push) begin
      offset_a     <= offset_a_next;
      offset_b     <= offset_b_next;
      decision     <= decision_next;
      centre_x_reg <= centre_x_next;
      centre_y_reg <= centre_y_next;
      active       <= !done_next;
    end
  end

endmodule

[design/bcr_queue.sv]
module bcr_queue #(
  parameter int WIDTH = 41,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             not_empty,
  output logic [WIDTH-1:0] head
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [AW:0]      count;

  assign full      = (count == (AW+1)'(DEPTH));
  assign not_empty = (count != '0);
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + AW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + AW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + (AW+1)'(1);
        2'b01:   count <= count - (AW+1)'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[design/bcr_back.sv]
module bcr_back #(
  parameter int COORD_BITS = 10
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_not_empty,
  input  logic [4*COORD_BITS:0]       q_head,
  output logic                        q_pop,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [2*(COORD_BITS+2)-1:0] out_data,
  output logic                        out_last,
  output logic                        out_done
);

  localparam int PW = COORD_BITS + 2;

  logic [COORD_BITS-1:0]          grp_cx, grp_cy, grp_x, grp_y;
  logic                           grp_done;
  logic                           grp_valid;
  logic [bcr_pkg::PHASE_W-1:0]    phase;

  logic        load;
  logic        last_load;
  logic [PW-1:0] cx_ext, cy_ext, a_ext, b_ext, px, py;

  assign load      = grp_valid && (!out_valid || out_ready);
  assign last_load = load && (phase == bcr_pkg::PHASE_LAST);
  assign q_pop     = q_not_empty && (!grp_valid || last_load);

  // Phase bit 2 swaps the roles of x and y, bits 0 and 1 mirror each axis.
  always_comb begin
    cx_ext = PW'(grp_cx);
    cy_ext = PW'(grp_cy);
    a_ext  = phase[2] ? PW'(grp_y) : PW'(grp_x);
    b_ext  = phase[2] ? PW'(grp_x) : PW'(grp_y);
    px     = phase[0] ? cx_ext - a_ext : cx_ext + a_ext;
    py     = phase[1] ? cy_ext - b_ext : cy_ext + b_ext;
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      {grp_done, grp_y, grp_x, grp_cy, grp_cx} <= q_head;
    end
    if (load) begin
      out_data <= {py, px};
      out_last <= (phase == bcr_pkg::PHASE_LAST);
      out_done <= grp_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      grp_valid <= 1'b0;
      phase     <= bcr_pkg::PHASE_FIRST;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (q_pop) begin
        grp_valid <= 1'b1;
        phase     <= bcr_pkg::PHASE_FIRST;
      end else begin
        if (last_load) begin
          grp_valid <= 1'b0;
        end
        if (load) begin
          phase <= phase + bcr_pkg::PHASE_W'(1);
        end
      end
    end
  end

endmodule

[design/bresenham_circle_raster_top.sv]
// Bresenham circle rasterizer with eightfold symmetry.
// Input items arrive on s_axis: tuser[0] is the opcode (0 starts a circle with
// the centre and radius in tdata, 1 advances one step). Output items leave on
// m_axis, one pixel each: tdata holds pixel_x then pixel_y as two's complement,
// tlast marks the eighth pixel of a step and tuser[0] is set on every pixel of
// the step that finishes the circle.
// A start, or an advance while a circle is running, yields eight output items,
// back to back when the receiver keeps tready high; the first passes through
// the queue, the group register and the output register. The output channel,
// at eight pixels per such item, sets the sustained input rate. An advance on
// an idle or finished circle is consumed and yields nothing.
// The step arithmetic completes in the cycle an item is accepted and the step
// result waits in a two-entry queue, so a new item is taken while earlier
// pixels are still draining. When the receiver stalls, the output register
// holds its pixel, the queue fills, and then s_axis_tready drops.
// Reset empties the queue and clears the output valid, the group valid and the
// running-circle flag; the block comes out of reset idle.
module bresenham_circle_raster_top #(
  parameter int COORD_BITS = 10
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // center_x, center_y, radius from bit 0 up, zero filled to bytes
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
  // func
  input  logic [0:0] s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // pixel_x, pixel_y from bit 0 up, zero filled to bytes
  output logic [((2*(COORD_BITS+2)+7)/8)*8-1:0] m_axis_tdata,
  output logic m_axis_tlast,
  // done_res
  output logic [0:0] m_axis_tuser
);

  localparam int GW          = 4*COORD_BITS + 1;
  localparam int PW          = COORD_BITS + 2;
  localparam int OUT_DW      = ((2*PW+7)/8)*8;
  localparam int QUEUE_DEPTH = 2;

  logic          push, q_full, q_pop, q_not_empty;
  logic [GW-1:0] push_data, q_head;
  logic [2*PW-1:0] pix_data;
  logic          pix_done;

  bcr_front #(
    .COORD_BITS(COORD_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .in_func  (s_axis_tuser[0]),
    .in_cx    (s_axis_tdata[COORD_BITS-1:0]),
    .in_cy    (s_axis_tdata[2*COORD_BITS-1:COORD_BITS]),
    .in_radius(s_axis_tdata[3*COORD_BITS-1:2*COORD_BITS]),
    .q_full   (q_full),
    .push     (push),
    .push_data(push_data)
  );

  bcr_queue #(
    .WIDTH(GW),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data(push_data),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head     (q_head)
  );

  bcr_back #(
    .COORD_BITS(COORD_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_data   (pix_data),
    .out_last   (m_axis_tlast),
    .out_done   (pix_done)
  );

  assign m_axis_tdata    = OUT_DW'(pix_data);
  assign m_axis_tuser[0] = pix_done;

  // The front never writes a step result into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_full)
    else $error("step result pushed into a full queue");

  // A group of eight pixels is never broken up: after a pixel that is not the
  // last of its group, the next one of the same step is presented at once.
  a_group_contiguous: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tready && !m_axis_tlast)
      |=> (m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser))))
    else $error("pixel group interrupted or done flag changed within a group");

  // Nothing is popped from an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_not_empty)
    else $error("queue popped while empty");

  // Reset leaves no pixel on the output.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

[tb/bresenham_circle_raster_top_tb.sv]
module bresenham_circle_raster_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CB = 10;
  localparam int PW = CB + 2;
  localparam int DW = CB + 4;
  localparam int IN_W = ((3 * CB + 7) / 8) * 8;
  localparam int OUT_W = ((2 * PW + 7) / 8) * 8;
  localparam int CYCLE_LIMIT = 500000;
  localparam int RANDOM_GROUPS = 385;

  typedef struct {
    logic [PW-1:0] px;
    logic [PW-1:0] py;
    logic          last;
    logic          fin;
  } pixel_t;

  logic clk = 1'b0;
  logic rst;
  logic s_axis_tvalid;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata;
  logic [0:0] s_axis_tuser;
  logic m_axis_tvalid;
  logic m_axis_tready;
  logic [OUT_W-1:0] m_axis_tdata;
  logic m_axis_tlast;
  logic [0:0] m_axis_tuser;

  // Predicted circle state, updated on every accepted start and on every accepted advance while a circle runs.
  logic [CB-1:0] pos_x = '0;
  logic [CB-1:0] pos_y = '0;
  logic [CB-1:0] ctr_x = '0;
  logic [CB-1:0] ctr_y = '0;
  logic [DW-1:0] dec_acc = '0;
  logic circ_run = 1'b0;

  pixel_t pixel_q[$];
  int groups_done = 0;
  int mismatches = 0;
  int cycle_count = 0;
  int in_gap_max = 17;
  int out_gap_max = 17;
  int hold_cycles = 0;

  bresenham_circle_raster_top #(.COORD_BITS(CB)) dut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .m_axis_tlast(m_axis_tlast),
    .m_axis_tuser(m_axis_tuser)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("%0t mismatch in %s: expected %0h, got %0h", $time, what, want, got);
    mismatches++;
  endtask

  // Queue the eight mirrored pixels of the current offsets.
  task automatic plot_octants(input logic fin);
    logic [PW-1:0] a;
    logic [PW-1:0] b;
    pixel_t p;
    for (int k = 0; k < 8; k++) begin
      a = (k < 4) ? PW'(pos_x) : PW'(pos_y);
      b = (k < 4) ? PW'(pos_y) : PW'(pos_x);
      p.px = (k & 1) ? PW'(ctr_x) - a : PW'(ctr_x) + a;
      p.py = (k & 2) ? PW'(ctr_y) - b : PW'(ctr_y) + b;
      p.last = (k == bcr_pkg::PHASE_LAST);
      p.fin = fin;
      pixel_q.push_back(p);
    end
  endtask

  task automatic bresenham_step(input logic func, input logic [CB-1:0] cx,
                                input logic [CB-1:0] cy, input logic [CB-1:0] r);
    logic fin;
    if (func == bcr_pkg::FUNC_ADVANCE && !circ_run) return;
    if (func == bcr_pkg::FUNC_START) begin
      ctr_x = cx;
      ctr_y = cy;
      pos_x = '0;
      pos_y = r;
      dec_acc = DW'(bcr_pkg::DEC_INIT) - (DW'(r) << 1);
    end else begin
      // The decision uses the offsets from before this step.
      if (dec_acc[DW-1]) begin
        dec_acc = dec_acc + (DW'(pos_x) << 2) + DW'(bcr_pkg::DEC_STEP_NEG);
      end else begin
        dec_acc = dec_acc + (DW'(pos_x) << 2) - (DW'(pos_y) << 2)
                  + DW'(bcr_pkg::DEC_STEP_POS);
        pos_y = pos_y - 1'b1;
      end
      pos_x = pos_x + 1'b1;
    end
    fin = (pos_x >= pos_y);
    circ_run = !fin;
    groups_done++;
    plot_octants(fin);
  endtask

  always @(posedge clk) begin : scoreboard
    pixel_t e;
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) begin
        bresenham_step(s_axis_tuser[0], s_axis_tdata[CB-1:0], s_axis_tdata[2*CB-1:CB],
                       s_axis_tdata[3*CB-1:2*CB]);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          report_mismatch("pixel with none pending", 0, 32'(m_axis_tdata));
        end else begin
          e = pixel_q.pop_front();
          if (m_axis_tdata[PW-1:0] !== e.px)
            report_mismatch("pixel_x", 32'(e.px), 32'(m_axis_tdata[PW-1:0]));
          if (m_axis_tdata[2*PW-1:PW] !== e.py)
            report_mismatch("pixel_y", 32'(e.py), 32'(m_axis_tdata[2*PW-1:PW]));
          if (m_axis_tlast !== e.last)
            report_mismatch("last_of_group", 32'(e.last), 32'(m_axis_tlast));
          if (m_axis_tuser[0] !== e.fin)
            report_mismatch("done_res", 32'(e.fin), 32'(m_axis_tuser[0]));
        end
      end
    end
  end

  // Receiver: random wait before each item, plus an optional long hold-off.
  initial begin : receiver
    int w;
    m_axis_tready = 1'b0;
    forever begin
      if (hold_cycles > 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end
      w = (out_gap_max > 0) ? $urandom_range(0, out_gap_max) : 0;
      if (w > 0) begin
        m_axis_tready <= 1'b0;
        repeat (w) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  // The valid stays high into the next item when no gap is drawn.
  task automatic send_item(input logic func, input logic [CB-1:0] cx,
                           input logic [CB-1:0] cy, input logic [CB-1:0] r);
    int gap;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_W'({r, cy, cx});
    s_axis_tuser <= func;
    do @(posedge clk); while (!s_axis_tready);
    gap = (in_gap_max > 0) ? $urandom_range(0, in_gap_max) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic advance_n(input int n);
    repeat (n) send_item(bcr_pkg::FUNC_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom));
  endtask

  // Waits for the clock first, so that the last accepted item is already predicted.
  task automatic drain;
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic test_idle_advance;
    send_item(bcr_pkg::FUNC_ADVANCE, 10'd1023, 10'd1023, 10'd1023);
    drain();
  endtask

  task automatic test_zero_radius;
    send_item(bcr_pkg::FUNC_START, 10'd0, 10'd0, 10'd0);
    send_item(bcr_pkg::FUNC_ADVANCE, 10'd0, 10'd0, 10'd0);
    send_item(bcr_pkg::FUNC_START, 10'd1023, 10'd1023, 10'd0);
    drain();
  endtask

  task automatic test_extremes;
    send_item(bcr_pkg::FUNC_START, 10'd1023, 10'd1023, 10'd1023);
    advance_n(3);
    send_item(bcr_pkg::FUNC_START, 10'd0, 10'd0, 10'd1023);
    advance_n(3);
    // Radius one finishes on the first advance; the second advance is ignored.
    send_item(bcr_pkg::FUNC_START, 10'd512, 10'd0, 10'd1);
    advance_n(2);
    drain();
  endtask

  task automatic test_restart;
    send_item(bcr_pkg::FUNC_START, 10'd100, 10'd200, 10'd1023);
    advance_n(2);
    send_item(bcr_pkg::FUNC_START, 10'd5, 10'd1000, 10'd5);
    advance_n(5);
    drain();
  endtask

  task automatic test_backpressure;
    in_gap_max = 0;
    out_gap_max = 0;
    hold_cycles = 400;
    send_item(bcr_pkg::FUNC_START, 10'd300, 10'd300, 10'd60);
    advance_n(20);
    drain();
    in_gap_max = 17;
    out_gap_max = 17;
  endtask

  task automatic test_random;
    int target;
    int n;
    logic [CB-1:0] r;
    target = groups_done + RANDOM_GROUPS;
    while (groups_done < target) begin
      in_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 17;
      // Occasional stray advances, often landing on an idle block.
      if ($urandom_range(0, 5) == 0) advance_n($urandom_range(1, 3));
      case ($urandom_range(0, 9))
        0: r = CB'($urandom_range(0, 1023));
        1, 2: r = CB'($urandom_range(25, 100));
        default: r = CB'($urandom_range(0, 24));
      endcase
      send_item(bcr_pkg::FUNC_START, CB'($urandom_range(0, 1023)),
                CB'($urandom_range(0, 1023)), r);
      n = (int'(r) * 707) / 1000 + $urandom_range(0, 2);
      if (r > 100) n = $urandom_range(1, 24);
      for (int i = 0; i < n; i++) begin
        // A start in the middle of a circle drops it.
        if ($urandom_range(0, 39) == 0) begin
          send_item(bcr_pkg::FUNC_START, CB'($urandom_range(0, 1023)),
                    CB'($urandom_range(0, 1023)), CB'($urandom_range(0, 24)));
        end else begin
          send_item(bcr_pkg::FUNC_ADVANCE, CB'($urandom), CB'($urandom), CB'($urandom));
        end
      end
    end
    drain();
    in_gap_max = 17;
    out_gap_max = 17;
  endtask

  initial begin
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    rst = 1'b1;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_idle_advance();
    test_zero_radius();
    test_extremes();
    test_restart();
    test_backpressure();
    test_random();
    if (pixel_q.size() != 0) report_mismatch("pixels never produced", 0, pixel_q.size());
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
